FILE: sv/wav_riff_header_parser_defines.svh
// ---------------------------------------------------------------------------
// wav_riff_header_parser_defines.svh
// assertion macros used by the header parser module
// ---------------------------------------------------------------------------
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define WRHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/wrhp_pkg.sv
// ---------------------------------------------------------------------------
// wrhp_pkg
// types, constants and format check of the riff/wave header parser
// ---------------------------------------------------------------------------
`default_nettype none

package wrhp_pkg;

  // width of the byte position counter, 16 to 32
  localparam int OFFSET_BITS = 32;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [31:0] MIN_HEADER_BYTES = 32'd20;
  localparam logic [31:0] DEFAULT_RATE_HIGH = 32'd44100;
  localparam logic [31:0] DEFAULT_RATE_LOW = 32'd22050;
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd2;
  localparam logic [15:0] DEFAULT_BITS = 16'd16;

  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
  localparam logic [31:0] SIZE_UNKNOWN = 32'hFFFF_FFFF;

  // tags, first byte in the low lane
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_HDR,
    PH_FMT,
    PH_SKIP
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TOO_SHORT   = 4'd1,
    ST_BAD_RIFF    = 4'd2,
    ST_BAD_WAVE    = 4'd3,
    ST_TRUNC       = 4'd4,
    ST_FMT_SMALL   = 4'd5,
    ST_FMT_CUT     = 4'd6,
    ST_FLOAT       = 4'd7,
    ST_EXT         = 4'd8,
    ST_UNKNOWN_FMT = 4'd9,
    ST_CHANNELS    = 4'd10,
    ST_RATE        = 4'd11,
    ST_BITS        = 4'd12,
    ST_NO_FMT      = 4'd13,
    ST_NO_DATA     = 4'd14
  } status_t;

  typedef enum logic [1:0] {
    CFG_RATE_HIGH,
    CFG_RATE_LOW,
    CFG_CHANNELS,
    CFG_BITS
  } cfg_index_t;

  // checks a complete fmt body against the configured format
  function automatic status_t fmt_check(
    input logic [15:0] fmt,
    input logic [15:0] chan,
    input logic [31:0] rate,
    input logic [15:0] bits,
    input logic [31:0] exp_high,
    input logic [31:0] exp_low,
    input logic [15:0] exp_chan,
    input logic [15:0] exp_bits
  );
    status_t st;
    if (fmt == FMT_FLOAT) st = ST_FLOAT;
    else if (fmt == FMT_EXTENSIBLE) st = ST_EXT;
    else if (fmt != FMT_PCM) st = ST_UNKNOWN_FMT;
    else if (chan != exp_chan) st = ST_CHANNELS;
    else if ((rate != exp_high) && (rate != exp_low)) st = ST_RATE;
    else if (bits != exp_bits) st = ST_BITS;
    else st = ST_OK;
    return st;
  endfunction

endpackage

`default_nettype wire

FILE: sv/wav_riff_header_parser.sv
// ---------------------------------------------------------------------------
// wav_riff_header_parser
// byte-stream riff/wave header parser with one result transaction per buffer
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | header_byte, last_byte
//  result   | out_valid / out_stall  | status, channels, audio_rate,
//           |                        | sample_width, pcm_offset, pcm_length,
//           |                        | unknown_length
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle sustained while the result side is not stalled; a result passes
// the input register, then one pass of parse logic into the result register.
// Reset clears the parse state and loads the default expected format.
// in_stall rises only while the input register holds a byte and the result
// register is full and stalled; configuration writes are always ready.
// ---------------------------------------------------------------------------
`default_nettype none
`include "wav_riff_header_parser_defines.svh"

module wav_riff_header_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           header_byte,
  input  wire logic                 last_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wrhp_pkg::status_t         status,
  output logic [15:0]               channels,
  output logic [31:0]               audio_rate,
  output logic [15:0]               sample_width,
  output logic [31:0]               pcm_offset,
  output logic [31:0]               pcm_length,
  output logic                      unknown_length,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire wrhp_pkg::cfg_index_t cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import wrhp_pkg::*;

  // configuration
  logic [31:0] expected_rate_high;
  logic [31:0] expected_rate_low;
  logic [15:0] expected_channels;
  logic [15:0] expected_bits;

  // input register
  logic       in_q_valid;
  logic [7:0] byte_q;
  logic       last_q;

  // parse state
  logic [OFFSET_BITS-1:0] pos, pos_next;
  phase_t      phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] body_remaining, body_remaining_next;
  logic [31:0] body_offset, body_offset_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_value, rate_value_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic        fmt_seen, fmt_seen_next;
  status_t     held_status, held_status_next;
  logic        finished, finished_next;

  // result of the current byte
  logic        res_valid;
  status_t     res_status;
  logic [15:0] res_channels;
  logic [31:0] res_rate;
  logic [15:0] res_bits;
  logic [31:0] res_offset;
  logic [31:0] res_size;
  logic        res_unknown;

  logic advance;
  logic step;

  // the input register moves on unless it holds a byte while the result register is full and stalled
  assign advance  = !in_q_valid || !out_valid || !out_stall;
  assign in_stall = !advance;
  assign step     = in_q_valid && advance;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate_high <= DEFAULT_RATE_HIGH;
      expected_rate_low  <= DEFAULT_RATE_LOW;
      expected_channels  <= DEFAULT_CHANNELS;
      expected_bits      <= DEFAULT_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE_HIGH: expected_rate_high <= cfg_data;
        CFG_RATE_LOW:  expected_rate_low  <= cfg_data;
        CFG_CHANNELS:  expected_channels  <= cfg_data[15:0];
        CFG_BITS:      expected_bits      <= cfg_data[15:0];
        default:       expected_bits      <= expected_bits;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (advance) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_q <= header_byte;
      last_q <= last_byte;
    end
  end

  // parse step for the byte in the input register
  always_comb begin
    logic        pad;
    logic [32:0] rem_full;
    status_t     chk;
    status_t     walk;

    pos_next            = pos;
    phase_next          = phase;
    hdr_count_next      = hdr_count;
    chunk_tag_next      = chunk_tag;
    chunk_length_next   = chunk_length;
    body_remaining_next = body_remaining;
    body_offset_next    = body_offset;
    format_code_next    = format_code;
    channel_count_next  = channel_count;
    rate_value_next     = rate_value;
    sample_bits_next    = sample_bits;
    fmt_seen_next       = fmt_seen;
    held_status_next    = held_status;
    finished_next       = finished;
    res_valid           = 1'b0;
    res_status          = ST_OK;
    res_channels        = '0;
    res_rate            = '0;
    res_bits            = '0;
    res_offset          = '0;
    res_size            = '0;
    res_unknown         = 1'b0;
    pad                 = 1'b0;
    rem_full            = '0;
    chk                 = ST_OK;
    walk                = ST_NO_FMT;

    if (!finished) begin
      if ((32'(pos) == MIN_HEADER_BYTES - 32'd1) && (held_status != ST_OK)) begin
        // preamble errors surface once the buffer is known to be long enough
        res_valid  = 1'b1;
        res_status = held_status;
      end else begin
        case (phase)
          PH_PRE: begin
            if ((pos < OFFSET_BITS'(4)) && (byte_q != TAG_RIFF[{pos[1:0], 3'b000} +: 8])
                && (held_status == ST_OK)) begin
              held_status_next = ST_BAD_RIFF;
            end
            if ((pos >= OFFSET_BITS'(8)) && (pos < OFFSET_BITS'(12))
                && (byte_q != TAG_WAVE[{pos[1:0], 3'b000} +: 8])
                && (held_status == ST_OK)) begin
              held_status_next = ST_BAD_WAVE;
            end
            if (pos >= OFFSET_BITS'(11)) begin
              phase_next        = PH_HDR;
              hdr_count_next    = '0;
              chunk_tag_next    = '0;
              chunk_length_next = '0;
            end
          end

          PH_HDR: begin
            // tag then length, little endian
            if (!hdr_count[2]) begin
              chunk_tag_next[{hdr_count[1:0], 3'b000} +: 8] =
                chunk_tag[{hdr_count[1:0], 3'b000} +: 8] | byte_q;
            end else begin
              chunk_length_next[{hdr_count[1:0], 3'b000} +: 8] =
                chunk_length[{hdr_count[1:0], 3'b000} +: 8] | byte_q;
            end
            hdr_count_next = hdr_count + 3'd1;
            if (hdr_count == 3'd7) begin
              pad      = chunk_length_next[0];
              rem_full = {1'b0, chunk_length_next} + {32'd0, pad};
              if (chunk_tag_next == TAG_FMT) begin
                if (chunk_length_next < 32'd16) begin
                  res_valid  = 1'b1;
                  res_status = ST_FMT_SMALL;
                end else begin
                  body_remaining_next = rem_full;
                  body_offset_next    = '0;
                  phase_next          = PH_FMT;
                end
              end else if (chunk_tag_next == TAG_DATA) begin
                res_valid  = 1'b1;
                res_status = fmt_seen ? ST_OK : ST_NO_FMT;
              end else begin
                body_remaining_next = rem_full;
                phase_next          = (rem_full != 33'd0) ? PH_SKIP : PH_HDR;
              end
              chunk_tag_next = '0;
              if ((res_valid || (phase_next == PH_HDR)) && !(res_valid && res_status == ST_OK))
              begin
                chunk_length_next = '0;
              end
            end
          end

          PH_FMT: begin
            // capture fields of the fmt body by offset
            if (body_offset < 32'd2) begin
              format_code_next[{body_offset[0], 3'b000} +: 8] = byte_q;
            end else if (body_offset < 32'd4) begin
              channel_count_next[{body_offset[0], 3'b000} +: 8] = byte_q;
            end else if (body_offset < 32'd8) begin
              rate_value_next[{body_offset[1:0], 3'b000} +: 8] = byte_q;
            end else if ((body_offset >= 32'd14) && (body_offset < 32'd16)) begin
              sample_bits_next[{body_offset[0], 3'b000} +: 8] = byte_q;
            end
            body_remaining_next = body_remaining - 33'd1;
            body_offset_next    = body_offset + 32'd1;
            if (({1'b0, body_offset} + 33'd1) == {1'b0, chunk_length}) begin
              chk = fmt_check(format_code_next, channel_count_next, rate_value_next,
                              sample_bits_next, expected_rate_high, expected_rate_low,
                              expected_channels, expected_bits);
              if (chk != ST_OK) begin
                res_valid  = 1'b1;
                res_status = chk;
              end else begin
                fmt_seen_next = 1'b1;
              end
            end
            if (!res_valid && (body_remaining_next == 33'd0)) begin
              phase_next        = PH_HDR;
              chunk_length_next = '0;
            end
          end

          PH_SKIP: begin
            body_remaining_next = body_remaining - 33'd1;
            if (body_remaining_next == 33'd0) begin
              phase_next        = PH_HDR;
              chunk_length_next = '0;
            end
          end

          default: begin
            phase_next = PH_PRE;
          end
        endcase
      end

      // end of buffer without a result yet
      if (!res_valid && last_q) begin
        res_valid = 1'b1;
        walk      = fmt_seen_next ? ST_NO_DATA : ST_NO_FMT;
        if ((32'(pos) + 32'd1) < MIN_HEADER_BYTES) begin
          res_status = ST_TOO_SHORT;
        end else begin
          case (phase_next)
            PH_HDR:  res_status = (hdr_count_next != 3'd0) ? ST_TRUNC : walk;
            PH_FMT:  res_status = (body_remaining_next > {32'd0, chunk_length_next[0]})
                                  ? ST_FMT_CUT : walk;
            PH_SKIP: res_status = (body_remaining_next > {32'd0, chunk_length_next[0]})
                                  ? ST_TRUNC : walk;
            default: res_status = ST_TOO_SHORT;
          endcase
        end
      end

      if (pos != POS_MAX) begin
        pos_next = pos + OFFSET_BITS'(1);
      end
    end

    // result payload, zero except for a good data header
    if (res_valid) begin
      finished_next = 1'b1;
      if (res_status == ST_OK) begin
        res_channels = channel_count_next;
        res_rate     = rate_value_next;
        res_bits     = sample_bits_next;
        res_offset   = 32'(pos_next);
        res_size     = chunk_length_next;
        res_unknown  = (chunk_length_next == SIZE_UNKNOWN);
      end
    end

    // the byte after the last one starts a new buffer
    if (last_q) begin
      pos_next            = '0;
      phase_next          = PH_PRE;
      hdr_count_next      = '0;
      chunk_tag_next      = '0;
      chunk_length_next   = '0;
      body_remaining_next = '0;
      body_offset_next    = '0;
      format_code_next    = '0;
      channel_count_next  = '0;
      rate_value_next     = '0;
      sample_bits_next    = '0;
      fmt_seen_next       = 1'b0;
      held_status_next    = ST_OK;
      finished_next       = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      phase          <= PH_PRE;
      hdr_count      <= '0;
      chunk_tag      <= '0;
      chunk_length   <= '0;
      body_remaining <= '0;
      body_offset    <= '0;
      format_code    <= '0;
      channel_count  <= '0;
      rate_value     <= '0;
      sample_bits    <= '0;
      fmt_seen       <= 1'b0;
      held_status    <= ST_OK;
      finished       <= 1'b0;
    end else if (step) begin
      pos            <= pos_next;
      phase          <= phase_next;
      hdr_count      <= hdr_count_next;
      chunk_tag      <= chunk_tag_next;
      chunk_length   <= chunk_length_next;
      body_remaining <= body_remaining_next;
      body_offset    <= body_offset_next;
      format_code    <= format_code_next;
      channel_count  <= channel_count_next;
      rate_value     <= rate_value_next;
      sample_bits    <= sample_bits_next;
      fmt_seen       <= fmt_seen_next;
      held_status    <= held_status_next;
      finished       <= finished_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      status         <= res_status;
      channels       <= res_channels;
      audio_rate     <= res_rate;
      sample_width   <= res_bits;
      pcm_offset     <= res_offset;
      pcm_length     <= res_size;
      unknown_length <= res_unknown;
    end
  end

  // checks
  `WRHP_ASSERT_NOW(a_err_fields_zero, clk, rst, out_valid && (status != ST_OK), (channels == 16'd0) && (audio_rate == 32'd0) && (pcm_offset == 32'd0) && (pcm_length == 32'd0) && !unknown_length, "error result carries nonzero fields")
  `WRHP_ASSERT_NOW(a_unknown_len, clk, rst, out_valid && (status == ST_OK), unknown_length == (pcm_length == SIZE_UNKNOWN), "unknown_length disagrees with pcm_length")
  `WRHP_ASSERT_NEXT(a_one_per_buffer, clk, rst, step && res_valid && !last_q, finished, "buffer not marked finished after its result")
  `WRHP_ASSERT_NOW(a_preamble_pos, clk, rst, phase == PH_PRE, pos <= OFFSET_BITS'(11), "preamble phase past byte 11")

endmodule

`default_nettype wire
